// ===== rtl/tcp_segment_checker_unit_macros.svh =====
// Assertion macros for the checker file tcs_checker.sv.
`ifndef TCP_SEGMENT_CHECKER_UNIT_MACROS_SVH
`define TCP_SEGMENT_CHECKER_UNIT_MACROS_SVH

// Checked only while reset is released.
`define TCS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define TCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tcs_pkg.sv =====
package tcs_pkg;

    localparam int unsigned MAX_SEGMENT_BYTES = 65535;
    localparam int unsigned MIN_HEADER_BYTES  = 20;
    localparam int unsigned COUNT_W           = 16;
    localparam logic [7:0]  PROTOCOL_TCP      = 8'd6;

    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 160;

    // Segment queue between the byte front end and the result back end.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_SHORT      = 2'd1,
        ST_BAD_OFFSET = 2'd2,
        ST_TOO_LONG   = 2'd3
    } t_status;

    typedef struct packed {
        logic               too_long;
        logic [COUNT_W-1:0] len;
        logic [31:0]        run_sum;
        logic [7:0]         held;
        logic [17:0]        addr_sum;
        logic [31:0]        ports;
        logic [63:0]        seq_ack;
        logic [3:0]         hdr_words;
        logic [5:0]         flags;
        logic [31:0]        win_urg;
    } t_seg_rec;

    typedef struct packed {
        logic [15:0] payload_length;
        logic        checksum_ok;
        logic [15:0] urgent_pointer;
        logic [15:0] window_size;
        logic [5:0]  flag_bits;
        logic [3:0]  header_words;
        logic [31:0] acknowledgement_number;
        logic [31:0] sequence_number;
        logic [15:0] destination_port;
        logic [15:0] source_port;
    } t_result;

endpackage

// ===== rtl/tcp_segment_checker_unit.sv =====
// Channel  Direction  Ports                                  Transaction
// s        in         s_tvalid s_tready s_tdata s_tlast      one segment byte
// m        out        m_tvalid m_tready m_tdata m_tuser      one checked segment
//
// One byte is taken per cycle while the segment queue has room.
// A result becomes valid after its segment leaves the queue and passes the registered sum stage, then the fold stage.
// Two finished segments can wait in the queue while the output is stalled.
// Synchronous active-low reset clears the front end's segment state and empties the queue and the pipeline.
module tcp_segment_checker_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // data_byte[7:0], source_address[39:8], destination_address[71:40]
    input  logic [tcs_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // source_port[15:0], destination_port[31:16], sequence_number[63:32],
    // acknowledgement_number[95:64], header_words[99:96], flag_bits[105:100],
    // window_size[121:106], urgent_pointer[137:122], checksum_ok[138],
    // payload_length[154:139], zero fill above
    output logic [tcs_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // status[1:0]
    output logic [1:0]                          m_tuser
);

    tcs_pkg::t_seg_rec front_rec, queue_rec;
    tcs_pkg::t_result  result;
    tcs_pkg::t_status  status;
    logic front_push, queue_not_full, queue_not_empty, back_pop;

    tcs_front u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (s_tvalid),
        .i_data_byte           (s_tdata[7:0]),
        .i_last_byte           (s_tlast),
        .i_source_address      (s_tdata[39:8]),
        .i_destination_address (s_tdata[71:40]),
        .i_queue_ready         (queue_not_full),
        .o_ready               (s_tready),
        .o_push                (front_push),
        .o_rec                 (front_rec)
    );

    tcs_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_push),
        .i_rec       (front_rec),
        .i_pop       (back_pop),
        .o_not_full  (queue_not_full),
        .o_not_empty (queue_not_empty),
        .o_rec       (queue_rec)
    );

    tcs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (queue_not_empty),
        .i_rec    (queue_rec),
        .o_pop    (back_pop),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_result (result),
        .o_status (status)
    );

    assign m_tdata = {(tcs_pkg::OUT_TDATA_W - $bits(tcs_pkg::t_result))'(0), result};
    assign m_tuser = status;

endmodule

// ===== rtl/tcs_front.sv =====
module tcs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  logic [31:0]       i_source_address,
    input  logic [31:0]       i_destination_address,
    input  logic              i_queue_ready,
    output logic              o_ready,
    output logic              o_push,
    output tcs_pkg::t_seg_rec o_rec
);

    localparam logic [tcs_pkg::COUNT_W-1:0] MAX_COUNT =
        tcs_pkg::COUNT_W'(tcs_pkg::MAX_SEGMENT_BYTES);

    logic [tcs_pkg::COUNT_W-1:0] r_count, n_count;
    logic [31:0] r_sum, n_sum;
    logic [7:0]  r_held, n_held;
    logic [17:0] r_addr_sum, n_addr_sum;
    logic [31:0] r_ports, n_ports;
    logic [63:0] r_seq_ack, n_seq_ack;
    logic [3:0]  r_hdr_words, n_hdr_words;
    logic [5:0]  r_flags, n_flags;
    logic [31:0] r_win_urg, n_win_urg;
    logic        r_too_long, n_too_long;
    logic        accept;

    assign o_ready = i_queue_ready;
    assign accept  = i_valid && i_queue_ready;
    assign o_push  = accept && i_last_byte;

    always_comb begin
        n_count     = r_count;
        n_sum       = r_sum;
        n_held      = r_held;
        n_addr_sum  = r_addr_sum;
        n_ports     = r_ports;
        n_seq_ack   = r_seq_ack;
        n_hdr_words = r_hdr_words;
        n_flags     = r_flags;
        n_win_urg   = r_win_urg;
        n_too_long  = r_too_long;
        if (accept) begin
            if (r_count == '0 && !r_too_long) begin
                n_addr_sum = {2'b00, i_source_address[31:16]}
                           + {2'b00, i_source_address[15:0]}
                           + {2'b00, i_destination_address[31:16]}
                           + {2'b00, i_destination_address[15:0]};
            end
            if (r_count >= MAX_COUNT) begin
                n_too_long = 1'b1;
            end else begin
                if (r_count < 16'd4) begin
                    n_ports = {r_ports[23:0], i_data_byte};
                end else if (r_count < 16'd12) begin
                    n_seq_ack = {r_seq_ack[55:0], i_data_byte};
                end else if (r_count == 16'd12) begin
                    n_hdr_words = i_data_byte[7:4];
                end else if (r_count == 16'd13) begin
                    n_flags = i_data_byte[5:0];
                end else if (r_count == 16'd14 || r_count == 16'd15
                             || r_count == 16'd18 || r_count == 16'd19) begin
                    n_win_urg = {r_win_urg[23:0], i_data_byte};
                end
                if (!r_count[0]) begin
                    n_held = i_data_byte;
                end else begin
                    n_sum = r_sum + {16'h0000, r_held, i_data_byte};
                end
                n_count = r_count + 1'b1;
            end
        end
    end

    always_comb begin
        o_rec.too_long  = n_too_long;
        o_rec.len       = n_count;
        o_rec.run_sum   = n_sum;
        o_rec.held      = n_held;
        o_rec.addr_sum  = n_addr_sum;
        o_rec.ports     = n_ports;
        o_rec.seq_ack   = n_seq_ack;
        o_rec.hdr_words = n_hdr_words;
        o_rec.flags     = n_flags;
        o_rec.win_urg   = n_win_urg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_count     <= '0;
            r_sum       <= '0;
            r_held      <= '0;
            r_addr_sum  <= '0;
            r_ports     <= '0;
            r_seq_ack   <= '0;
            r_hdr_words <= '0;
            r_flags     <= '0;
            r_win_urg   <= '0;
            r_too_long  <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_held      <= n_held;
            r_addr_sum  <= n_addr_sum;
            r_ports     <= n_ports;
            r_seq_ack   <= n_seq_ack;
            r_hdr_words <= n_hdr_words;
            r_flags     <= n_flags;
            r_win_urg   <= n_win_urg;
            r_too_long  <= n_too_long;
        end
    end

endmodule

// ===== rtl/tcs_queue.sv =====
module tcs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tcs_pkg::t_seg_rec i_rec,
    input  logic              i_pop,
    output logic              o_not_full,
    output logic              o_not_empty,
    output tcs_pkg::t_seg_rec o_rec
);

    localparam logic [tcs_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        tcs_pkg::QUEUE_PTR_W'(tcs_pkg::QUEUE_DEPTH - 1);
    localparam logic [tcs_pkg::QUEUE_CNT_W-1:0] FULL_CNT =
        tcs_pkg::QUEUE_CNT_W'(tcs_pkg::QUEUE_DEPTH);

    tcs_pkg::t_seg_rec r_mem [tcs_pkg::QUEUE_DEPTH];
    logic [tcs_pkg::QUEUE_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [tcs_pkg::QUEUE_CNT_W-1:0] r_cnt;
    logic do_push, do_pop;

    assign o_not_full  = (r_cnt != FULL_CNT);
    assign o_not_empty = (r_cnt != '0);
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_not_empty;
    assign o_rec       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/tcs_back.sv =====
module tcs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  tcs_pkg::t_seg_rec i_rec,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output tcs_pkg::t_result  o_result,
    output tcs_pkg::t_status  o_status
);

    localparam logic [tcs_pkg::COUNT_W-1:0] MIN_LEN =
        tcs_pkg::COUNT_W'(tcs_pkg::MIN_HEADER_BYTES);

    logic                        r_s1_valid;
    logic [31:0]                 r_s1_sum;
    logic                        r_s1_keep;
    tcs_pkg::t_status            r_s1_status;
    tcs_pkg::t_result            r_s1_result;
    logic                        r_o_valid;
    tcs_pkg::t_status            r_o_status;
    tcs_pkg::t_result            r_o_result;

    tcs_pkg::t_status            n_status;
    tcs_pkg::t_result            n_s1_result;
    tcs_pkg::t_result            n_o_result;
    logic [31:0]                 n_sum;
    logic [tcs_pkg::COUNT_W-1:0] hdr_len;
    logic [7:0]                  pad_byte;
    logic [16:0]                 fold;
    logic                        adv_o, load_s1;

    assign adv_o   = !r_o_valid || i_ready;
    assign load_s1 = !r_s1_valid || adv_o;
    assign o_pop   = i_valid && load_s1;

    always_comb begin
        hdr_len  = {10'b0, i_rec.hdr_words, 2'b00};
        pad_byte = i_rec.len[0] ? i_rec.held : 8'h00;
        n_sum    = i_rec.run_sum
                 + {16'h0000, pad_byte, 8'h00}
                 + {14'b0, i_rec.addr_sum}
                 + {24'b0, tcs_pkg::PROTOCOL_TCP}
                 + {16'h0000, i_rec.len};
        if (i_rec.too_long) begin
            n_status = tcs_pkg::ST_TOO_LONG;
        end else if (i_rec.len < MIN_LEN) begin
            n_status = tcs_pkg::ST_SHORT;
        end else if (hdr_len < MIN_LEN || hdr_len > i_rec.len) begin
            n_status = tcs_pkg::ST_BAD_OFFSET;
        end else begin
            n_status = tcs_pkg::ST_OK;
        end
        n_s1_result = '0;
        if (n_status == tcs_pkg::ST_OK || n_status == tcs_pkg::ST_BAD_OFFSET) begin
            n_s1_result.source_port            = i_rec.ports[31:16];
            n_s1_result.destination_port       = i_rec.ports[15:0];
            n_s1_result.sequence_number        = i_rec.seq_ack[63:32];
            n_s1_result.acknowledgement_number = i_rec.seq_ack[31:0];
            n_s1_result.header_words           = i_rec.hdr_words;
            n_s1_result.flag_bits              = i_rec.flags;
            n_s1_result.window_size            = i_rec.win_urg[31:16];
            n_s1_result.urgent_pointer         = i_rec.win_urg[15:0];
        end
        if (n_status == tcs_pkg::ST_OK) begin
            n_s1_result.payload_length = i_rec.len - hdr_len;
        end
    end

    always_comb begin
        fold       = {1'b0, r_s1_sum[31:16]} + {1'b0, r_s1_sum[15:0]};
        n_o_result = r_s1_result;
        n_o_result.checksum_ok = r_s1_keep && (fold == 17'h0FFFF || fold == 17'h1FFFE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (load_s1) begin
                r_s1_valid <= i_valid;
            end
            if (adv_o) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_sum    <= n_sum;
            r_s1_status <= n_status;
            r_s1_keep   <= (n_status == tcs_pkg::ST_OK || n_status == tcs_pkg::ST_BAD_OFFSET);
            r_s1_result <= n_s1_result;
        end
        if (adv_o && r_s1_valid) begin
            r_o_status <= r_s1_status;
            r_o_result <= n_o_result;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_result = r_o_result;
    assign o_status = r_o_status;

endmodule

// ===== rtl/tcs_checker.sv =====
`include "tcp_segment_checker_unit_macros.svh"

module tcs_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [tcs_pkg::IN_TDATA_W-1:0]  s_tdata,
    input logic                            s_tlast,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tcs_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [1:0]                      m_tuser
);

    `TCS_ASSERT(a_out_hold, i_clk, i_rst_n, (m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "Result changed while stalled.")

    `TCS_ASSERT_ALWAYS(a_reset_clear, i_clk, (!i_rst_n |=> !m_tvalid && s_tready), "Reset did not empty the pipeline.")

    `TCS_ASSERT(a_error_zero, i_clk, i_rst_n, (m_tvalid && (m_tuser == tcs_pkg::ST_SHORT || m_tuser == tcs_pkg::ST_TOO_LONG) |-> m_tdata == '0), "Short or long segment reported fields.")

    `TCS_ASSERT(a_bad_offset_payload, i_clk, i_rst_n, (m_tvalid && m_tuser == tcs_pkg::ST_BAD_OFFSET |-> m_tdata[154:139] == 16'h0000), "Bad offset reported a payload length.")

endmodule

bind tcp_segment_checker_unit tcs_checker u_tcs_checker (.*);
